@@ design/ipc_pkg.sv @@
// Shared types and constants for the infrared pulse timing capture block.
`default_nettype none

package ipc_pkg;

  // Timing buffer size and derived widths
  localparam int unsigned Capacity = 160;
  localparam int unsigned CntW     = 8;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned TimeW    = 16;
  localparam int unsigned IdxW     = 8;

  localparam logic [CntW-1:0]  CapCnt       = CntW'(Capacity);
  localparam logic [TimeW-1:0] TimeoutReset = TimeW'(62500);

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KindTick    = 2'd0,
    KindEdge    = 2'd1,
    KindRead    = 2'd2,
    KindRelease = 2'd3
  } kind_e;

  // Buffer write request from the capture state to the timing store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] data;
  } wr_req_t;

  // Status of one transaction, state after the item
  typedef struct packed {
    logic            done;
    logic [CntW-1:0] count;
    logic            level;
    logic            hit;
  } res_t;

endpackage

`default_nettype wire

@@ design/ir_pulse_timing_capture.sv @@
// Top level: infrared pulse timing capture with timing store and output skid stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transaction:
//   kind_i selects tick, pin edge, entry read or release; read_index_i is the
//   entry to read. Every item yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): capture_done_o, entry_count_o, read_value_o and
//   line_level_o, all showing the state after the item.
//   Throughput is one item per cycle while in_stall_o is low; the state update
//   and the timing store write/read (one write port, one registered read port)
//   finish in the cycle the item is taken, and the result is then registered.
//   When the receiver stalls, the result holds and one more item is taken into
//   a skid register; in_stall_o then rises until the output drains.
//   The timeout register is written over cfg_valid_i / cfg_data_i, ready always.
//   Reset clears the counter, count and done flag, sets the level high and
//   loads a timeout of 62500 ticks. The timing store is not cleared; entries
//   at or beyond the count read as zero.
`default_nettype none

module ir_pulse_timing_capture (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                kind_i,
  input  wire logic [ipc_pkg::IdxW-1:0]  read_index_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           capture_done_o,
  output logic [ipc_pkg::CntW-1:0]       entry_count_o,
  output logic [ipc_pkg::TimeW-1:0]      read_value_o,
  output logic                           line_level_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [ipc_pkg::TimeW-1:0] cfg_data_i
);

  logic [ipc_pkg::TimeW-1:0] mem_q [ipc_pkg::Capacity];

  logic                      acc, out_take, load_out, load_skid, skid_move;
  logic [ipc_pkg::AddrW-1:0] rd_addr;
  ipc_pkg::wr_req_t          wr;
  ipc_pkg::res_t             res;
  logic                      out_vld_q, skid_vld_q;
  ipc_pkg::res_t             out_res_q, skid_res_q;
  logic [ipc_pkg::TimeW-1:0] out_rd_q, skid_rd_q;

  assign cfg_ready_o = 1'b1;

  // Handshake
  assign acc       = in_valid_i & ~skid_vld_q;
  assign out_take  = out_vld_q & ~out_stall_i;
  assign load_out  = acc & (~out_vld_q | out_take);
  assign load_skid = acc & out_vld_q & ~out_take;
  assign skid_move = skid_vld_q & out_take;
  assign rd_addr   = read_index_i[ipc_pkg::AddrW-1:0];

  ipc_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .kind_i       (ipc_pkg::kind_e'(kind_i)),
    .read_index_i (read_index_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .wr_o         (wr),
    .res_o        (res)
  );

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (load_out || skid_move) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
      if (load_skid) begin
        skid_vld_q <= 1'b1;
      end else if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  // Timing store write, registered read into output or skid slot
  always_ff @(posedge clk_i) begin
    if (wr.we) begin
      mem_q[wr.addr] <= wr.data;
    end
    if (load_out) begin
      out_res_q <= res;
      out_rd_q  <= mem_q[rd_addr];
    end else if (skid_move) begin
      out_res_q <= skid_res_q;
      out_rd_q  <= skid_rd_q;
    end
    if (load_skid) begin
      skid_res_q <= res;
      skid_rd_q  <= mem_q[rd_addr];
    end
  end

  assign in_stall_o     = skid_vld_q;
  assign out_valid_o    = out_vld_q;
  assign capture_done_o = out_res_q.done;
  assign entry_count_o  = out_res_q.count;
  assign line_level_o   = out_res_q.level;
  assign read_value_o   = out_res_q.hit ? out_rd_q : '0;

endmodule

`default_nettype wire

@@ design/ipc_state.sv @@
// Capture control state: tick counter, fill count, level and done flags, timeout register.
`default_nettype none

module ipc_state (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  wire ipc_pkg::kind_e            kind_i,
  input  wire logic [ipc_pkg::IdxW-1:0]  read_index_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [ipc_pkg::TimeW-1:0] cfg_data_i,
  output ipc_pkg::wr_req_t               wr_o,
  output ipc_pkg::res_t                  res_o
);

  logic [ipc_pkg::TimeW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [ipc_pkg::TimeW-1:0] timeout_q;
  logic [ipc_pkg::CntW-1:0]  fill_q, fill_d;
  logic                      level_q, level_d;
  logic                      done_q, done_d;
  logic                      hit;
  ipc_pkg::wr_req_t          wr;

  assign cnt_inc = cnt_q + 1'b1;

  // Next state for the item at the input
  always_comb begin
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    level_d = level_q;
    done_d  = done_q;
    hit     = 1'b0;
    wr.we   = 1'b0;
    wr.addr = fill_q[ipc_pkg::AddrW-1:0];
    wr.data = '0;
    case (kind_i)
      ipc_pkg::KindTick: begin
        cnt_d = cnt_inc;
        if (cnt_inc == timeout_q) begin
          cnt_d = '0;
          // silent gap ends a non-empty capture; pad an odd count with a zero off-time
          if (!done_q && (fill_q != '0)) begin
            if (fill_q[0] && (fill_q < ipc_pkg::CapCnt)) begin
              wr.we  = 1'b1;
              fill_d = fill_q + 1'b1;
            end
            done_d = 1'b1;
          end
        end
      end
      ipc_pkg::KindEdge: begin
        if (!done_q && (fill_q < ipc_pkg::CapCnt)) begin
          // first edge from idle only starts timing
          if (!(level_q && (fill_q == '0))) begin
            wr.we   = 1'b1;
            wr.data = cnt_q;
            fill_d  = fill_q + 1'b1;
          end
          cnt_d   = '0;
          level_d = ~level_q;
        end
      end
      ipc_pkg::KindRead: begin
        hit = (read_index_i < fill_q);
      end
      ipc_pkg::KindRelease: begin
        fill_d  = '0;
        done_d  = 1'b0;
        level_d = 1'b1;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      fill_q    <= '0;
      level_q   <= 1'b1;
      done_q    <= 1'b0;
      timeout_q <= ipc_pkg::TimeoutReset;
    end else begin
      if (acc_i) begin
        cnt_q   <= cnt_d;
        fill_q  <= fill_d;
        level_q <= level_d;
        done_q  <= done_d;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  assign wr_o.we    = wr.we & acc_i;
  assign wr_o.addr  = wr.addr;
  assign wr_o.data  = wr.data;
  assign res_o.done  = done_d;
  assign res_o.count = fill_d;
  assign res_o.level = level_d;
  assign res_o.hit   = hit;

endmodule

`default_nettype wire

@@ design/ipc_checker.sv @@
// Port-level checks for the infrared pulse timing capture block, bound to the top level.
`default_nettype none

module ipc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic                      capture_done_o,
  input wire logic [ipc_pkg::CntW-1:0]  entry_count_o,
  input wire logic [ipc_pkg::TimeW-1:0] read_value_o,
  input wire logic                      line_level_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o)
      && $stable(read_value_o) && $stable(capture_done_o) && $stable(line_level_o))
    else $error("stalled result changed");

  // Input only stalls while a result is waiting
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Count never exceeds the buffer size
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= ipc_pkg::CapCnt)
    else $error("entry count beyond capacity");

  // A finished capture holds an even count unless the buffer is full
  a_done_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_done_o |-> !entry_count_o[0] || entry_count_o == ipc_pkg::CapCnt)
    else $error("capture done with odd count");

endmodule

bind ir_pulse_timing_capture ipc_checker u_ipc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .capture_done_o (capture_done_o),
  .entry_count_o  (entry_count_o),
  .read_value_o   (read_value_o),
  .line_level_o   (line_level_o)
);

`default_nettype wire

@@ sim/tb_ir_pulse_timing_capture.sv @@
// Testbench for ir_pulse_timing_capture: queued stimulus, status prediction, result checking.
module tb_ir_pulse_timing_capture;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogNs = 16_000_000;

  typedef struct {
    ipc_pkg::kind_e            kind;
    logic [ipc_pkg::IdxW-1:0]  idx;
  } capture_item_t;

  typedef struct {
    logic                      done;
    logic [ipc_pkg::CntW-1:0]  count;
    logic [ipc_pkg::TimeW-1:0] value;
    logic                      level;
  } capture_status_t;

  // Clock, reset and DUT ports
  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  ipc_pkg::kind_e            in_kind    = ipc_pkg::KindTick;
  logic [ipc_pkg::IdxW-1:0]  in_index   = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic                      cap_done;
  logic [ipc_pkg::CntW-1:0]  entry_count;
  logic [ipc_pkg::TimeW-1:0] read_value;
  logic                      line_level;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [ipc_pkg::TimeW-1:0] cfg_data   = '0;

  // Idle control
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold       = 1'b0;
  event        hold_start;

  // Stimulus and expected status
  capture_item_t   pending_items[$];
  capture_status_t expected_status[$];
  capture_item_t   next_item;
  capture_status_t want;

  // Predicted capture state
  logic [ipc_pkg::TimeW-1:0] pulse_mem [ipc_pkg::Capacity];
  logic [ipc_pkg::CntW-1:0]  pulse_cnt  = '0;
  logic                      line_hi    = 1'b1;
  logic                      code_done  = 1'b0;
  logic [ipc_pkg::TimeW-1:0] tick_cnt   = '0;
  logic [ipc_pkg::TimeW-1:0] tmo_ticks  = ipc_pkg::TimeoutReset;

  // Run statistics
  int unsigned items_queued    = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned errors          = 0;
  int unsigned settings_used   = 1;
  int unsigned captures_ended  = 0;
  int unsigned full_captures   = 0;

  ir_pulse_timing_capture DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (in_kind),
    .read_index_i   (in_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .capture_done_o (cap_done),
    .entry_count_o  (entry_count),
    .read_value_o   (read_value),
    .line_level_o   (line_level),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append a timing if the buffer has room
  function automatic void store_timing(input logic [ipc_pkg::TimeW-1:0] v);
    if (pulse_cnt < ipc_pkg::CapCnt) begin
      pulse_mem[pulse_cnt] = v;
      pulse_cnt = pulse_cnt + 1'b1;
    end
  endfunction

  // Apply one transaction to the predicted state and queue the status it yields
  task automatic advance_capture(input ipc_pkg::kind_e k, input logic [ipc_pkg::IdxW-1:0] idx);
    capture_status_t s;
    s.value = '0;
    case (k)
      ipc_pkg::KindTick: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt == tmo_ticks) begin
          tick_cnt = '0;
          // silent gap ends a non-empty capture, padding an odd count
          if (!code_done && pulse_cnt != '0) begin
            if (pulse_cnt[0]) store_timing('0);
            code_done = 1'b1;
            captures_ended++;
            if (pulse_cnt == ipc_pkg::CapCnt) full_captures++;
          end
        end
      end
      ipc_pkg::KindEdge: begin
        if (!code_done && pulse_cnt < ipc_pkg::CapCnt) begin
          // first edge out of idle only starts the timer
          if (!(line_hi && pulse_cnt == '0)) store_timing(tick_cnt);
          tick_cnt = '0;
          line_hi  = ~line_hi;
        end
      end
      ipc_pkg::KindRead: begin
        if (idx < pulse_cnt) s.value = pulse_mem[idx];
      end
      ipc_pkg::KindRelease: begin
        pulse_cnt = '0;
        code_done = 1'b0;
        line_hi   = 1'b1;
      end
      default: begin
      end
    endcase
    s.done  = code_done;
    s.count = pulse_cnt;
    s.level = line_hi;
    expected_status.push_back(s);
  endtask

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic bit capture_idle();
    return pending_items.size() == 0 && !in_valid && expected_status.size() == 0;
  endfunction

  function automatic logic [ipc_pkg::IdxW-1:0] any_index();
    return ipc_pkg::IdxW'($urandom_range(255));
  endfunction

  // Input driver: predicts each accepted transaction, then offers the next item
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_capture(in_kind, in_index);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind  <= next_item.kind;
          in_index <= next_item.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted result against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_status.size() == 0) begin
          flag_error("result with no transaction pending");
        end else begin
          want = expected_status.pop_front();
          if (cap_done !== want.done)
            flag_error($sformatf("result %0d capture_done: expected %0d, got %0d",
                                 results_checked, want.done, cap_done));
          if (entry_count !== want.count)
            flag_error($sformatf("result %0d entry_count: expected %0d, got %0d",
                                 results_checked, want.count, entry_count));
          if (read_value !== want.value)
            flag_error($sformatf("result %0d read_value: expected %0d, got %0d",
                                 results_checked, want.value, read_value));
          if (line_level !== want.level)
            flag_error($sformatf("result %0d line_level: expected %0d, got %0d",
                                 results_checked, want.level, line_level));
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here in clock cycles
  always begin
    @(hold_start);
    rx_hold = 1'b1;
    repeat (80) @(negedge clk);
    rx_hold = 1'b0;
  end

  task automatic push_item(input ipc_pkg::kind_e k, input logic [ipc_pkg::IdxW-1:0] idx);
    capture_item_t it;
    it.kind = k;
    it.idx  = idx;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_ticks(input int unsigned n);
    repeat (n) push_item(ipc_pkg::KindTick, any_index());
  endtask

  // Wait until every queued item is taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk); while (!capture_idle());
    repeat (2) @(negedge clk);
  endtask

  // Timeout register write, only while the block is idle
  task automatic write_timeout(input logic [ipc_pkg::TimeW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tmo_ticks = v;
    settings_used++;
    @(negedge clk);
  endtask

  // One capture: optional release, edges with gaps, silent gap, reads, optional release.
  // Some sessions are plain noise instead.
  task automatic queue_capture_session(input bit long_code);
    int unsigned n_edges;
    int unsigned gap_max;
    int unsigned silent;
    int unsigned hi_idx;
    if (!long_code && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12))
        push_item(ipc_pkg::kind_e'($urandom_range(3)), any_index());
      return;
    end
    n_edges = long_code ? $urandom_range(162, 175) : $urandom_range(1, 24);
    gap_max = (tmo_ticks > 16'd1) ? tmo_ticks - 1 : 0;
    if (long_code && gap_max > 3) gap_max = 3;
    if (gap_max > 60) gap_max = 60;
    if ($urandom_range(3) != 0) push_item(ipc_pkg::KindRelease, any_index());
    repeat (n_edges) begin
      queue_ticks($urandom_range(0, gap_max));
      push_item(ipc_pkg::KindEdge, any_index());
    end
    // occasionally cut the silent gap short
    silent = tmo_ticks;
    if ($urandom_range(9) == 0) silent = $urandom_range(0, tmo_ticks);
    queue_ticks(silent);
    hi_idx = (n_edges + 1 > 255) ? 255 : n_edges + 1;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(3) == 0) push_item(ipc_pkg::KindRead, any_index());
      else push_item(ipc_pkg::KindRead, ipc_pkg::IdxW'($urandom_range(0, hi_idx)));
    end
    if ($urandom_range(4) != 0) push_item(ipc_pkg::KindRelease, any_index());
  endtask

  // Hard time limit
  initial begin
    #(WatchdogNs);
    $display("Mismatches found");
    $finish;
  end

  // Test sequence
  initial begin
    int unsigned target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset timeout, basic captures, reads in and out of range
    send_idle_pct = 8;
    recv_idle_pct = 78;
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(3);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(1);
    push_item(ipc_pkg::KindEdge, any_index());
    push_item(ipc_pkg::KindRead, 8'd0);
    push_item(ipc_pkg::KindRead, 8'd1);
    push_item(ipc_pkg::KindRead, 8'd2);
    push_item(ipc_pkg::KindRead, 8'd255);
    push_item(ipc_pkg::KindRelease, any_index());
    push_item(ipc_pkg::KindRead, 8'd0);
    wait_drained();

    // Directed: empty timeout, odd-count padding, edge ignored while done
    write_timeout(16'd3);
    queue_ticks(3);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(1);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(3);
    push_item(ipc_pkg::KindEdge, any_index());
    push_item(ipc_pkg::KindRead, 8'd1);
    push_item(ipc_pkg::KindRelease, any_index());
    wait_drained();

    // Random, receiver mostly stalled
    write_timeout(16'd25);
    target = items_queued + 250;
    while (items_queued < target) queue_capture_session(1'b0);
    wait_drained();

    // Random, sender mostly idle; shortest timeout then a small one
    send_idle_pct = 78;
    recv_idle_pct = 8;
    write_timeout(16'd1);
    target = items_queued + 80;
    while (items_queued < target) queue_capture_session(1'b0);
    wait_drained();
    write_timeout(16'd9);
    target = items_queued + 180;
    while (items_queued < target) queue_capture_session(1'b0);
    wait_drained();

    // Full rate; buffer overflow, then a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(16'd20);
    queue_capture_session(1'b1);
    target = items_queued + 150;
    while (items_queued < target) queue_capture_session(1'b0);
    @(negedge clk);
    -> hold_start;
    target = items_queued + 120;
    while (items_queued < target) queue_capture_session(1'b0);
    wait_drained();

    // Largest timeout: a long silent gap does not end the capture
    write_timeout(16'hFFFF);
    push_item(ipc_pkg::KindRelease, any_index());
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(7);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(100);
    push_item(ipc_pkg::KindRead, 8'd0);
    push_item(ipc_pkg::KindRead, 8'd1);
    push_item(ipc_pkg::KindRelease, any_index());
    wait_drained();

    // Zero timeout: the counter never matches early and keeps running
    write_timeout(16'h0000);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(2);
    push_item(ipc_pkg::KindEdge, any_index());
    queue_ticks(100);
    push_item(ipc_pkg::KindRead, 8'd0);
    push_item(ipc_pkg::KindRead, 8'd1);
    push_item(ipc_pkg::KindRelease, any_index());
    wait_drained();
    repeat (4) @(negedge clk);

    $display("Run summary: %0d transactions taken, %0d results checked, %0d timeout settings",
             items_accepted, results_checked, settings_used);
    $display("Run summary: %0d captures closed by timeout, %0d of them with a full buffer",
             captures_ended, full_captures);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors in total", errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ipc_pkg.sv
design/ipc_state.sv
design/ir_pulse_timing_capture.sv
design/ipc_checker.sv
sim/tb_ir_pulse_timing_capture.sv
